### hdl/khc_pkg.sv
// ---------------------------------------------------------------------------
// khc_pkg: key handle cache shared definitions
// Opcodes, field widths, parameter defaults and the per-slot command struct.
// ---------------------------------------------------------------------------
package khc_pkg;

    // Field widths of the request and result items
    localparam int USER_W      = 64;
    localparam int PROFILE_W   = 32;
    localparam int KEY_FIELD_W = 32;
    localparam int CAP_W       = 5;

    // Parameter defaults
    localparam int ENTRIES_DEF     = 16;
    localparam int HANDLE_BITS_DEF = 32;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request opcodes; the fourth code is unused and changes nothing
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    // Broadcast command from the control logic to every slot
    typedef struct packed {
        logic clear;      // empty the whole store
        logic insert;     // an insert is executing this cycle
        logic any_match;  // the request tag matched a valid slot
    } khc_cmd_t;

endpackage

### hdl/khc_cell.sv
// ---------------------------------------------------------------------------
// khc_cell: one cache slot
// Holds tag, key handle, delegate flag and age rank of one entry, compares
// the tag of the current request and updates its own rank.
// ---------------------------------------------------------------------------
module khc_cell
    import khc_pkg::*;
#(
    parameter int AGE_W = 4,
    parameter int KEY_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  khc_cmd_t             cmd,
    input  logic [AGE_W-1:0]     ref_age,    // rank of the matching slot
    input  logic                 kill,       // remove this slot
    input  logic                 fill,       // write the new entry here
    input  logic [USER_W-1:0]    user_id,
    input  logic [PROFILE_W-1:0] profile_id,
    input  logic [KEY_W-1:0]     key_handle,
    input  logic                 delegate,
    output logic                 valid,
    output logic                 match,
    output logic [AGE_W-1:0]     age_q,      // current rank
    output logic [AGE_W-1:0]     age_drop,   // rank once the matching slot leaves
    output logic [KEY_W-1:0]     key_q,
    output logic                 delegate_q
);

    logic                 valid_reg;
    logic [AGE_W-1:0]     age_reg;
    logic [USER_W-1:0]    user_reg;
    logic [PROFILE_W-1:0] profile_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 delegate_reg;

    // Compare the request tag
    assign match = valid_reg && (user_reg == user_id) && (profile_reg == profile_id);

    // Close the gap left by a removed younger entry
    always_comb
    begin
        if (cmd.any_match && (age_reg > ref_age))
            age_drop = age_reg - AGE_W'(1);
        else
            age_drop = age_reg;
    end

    // Hold valid flag and rank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else if (cmd.insert)
        begin
            if (fill)
            begin
                valid_reg <= 1'b1;
                age_reg   <= '0;
            end
            else if (kill)
                valid_reg <= 1'b0;
            else if (valid_reg)
                age_reg <= age_drop + AGE_W'(1);
        end
    end

    // Store the payload of a new entry
    always_ff @(posedge clk)
    begin
        if (cmd.insert && fill)
        begin
            user_reg     <= user_id;
            profile_reg  <= profile_id;
            key_reg      <= key_handle;
            delegate_reg <= delegate;
        end
    end

    assign valid      = valid_reg;
    assign age_q      = age_reg;
    assign key_q      = key_reg;
    assign delegate_q = delegate_reg;

endmodule

### hdl/key_handle_cache_fifo_replace.sv
// Key handle cache with first-in first-out replacement. Every request (lookup,
// insert or clear) is captured in an input register, runs through the tag
// compare and rank update of all slots and leaves a result in the output
// register, so one request is taken per clock and its result is offered
// on m_tvalid from that register. Throughput drops only while the result
// register waits for m_tready. A capacity write takes effect for the
// next insert; a capacity of zero acts as one and a value above ENTRIES acts
// as ENTRIES.
// ---------------------------------------------------------------------------
// key_handle_cache_fifo_replace: fully associative key handle cache
// Tags are (user id, profile id); entries leave oldest first once the
// capacity is reached. Lookups do not reorder entries.
// ---------------------------------------------------------------------------
module key_handle_cache_fifo_replace
    import khc_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Capacity register write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    // Requests
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [135:0]     s_tdata,   // user_id[63:0], profile_id[95:64],
                                        // key_handle_in[127:96], delegate_in[128]
    input  logic [1:0]       s_tuser,   // opcode[1:0]
    // Results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,   // key_handle_out[31:0], delegate_out[32],
                                        // evicted[33]
    output logic             m_tuser    // hit[0]
);

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W = (HANDLE_BITS < KEY_FIELD_W) ? HANDLE_BITS : KEY_FIELD_W;

    // Input register
    logic                   in_valid_reg;
    opcode_t                op_reg;
    logic [USER_W-1:0]      user_reg;
    logic [PROFILE_W-1:0]   profile_reg;
    logic [KEY_FIELD_W-1:0] key_in_reg;
    logic                   dlg_in_reg;

    // Result register
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [KEY_FIELD_W-1:0] key_out_reg;
    logic                   dlg_out_reg;
    logic                   evicted_reg;

    logic                   hit_next;
    logic [KEY_FIELD_W-1:0] key_out_next;
    logic                   dlg_out_next;
    logic                   evicted_next;

    // Control state
    logic [CAP_W-1:0]       capacity_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   advance;
    logic                   do_insert;
    khc_cmd_t               cmd;

    // Per-slot signals
    logic [ENTRIES-1:0]     slot_valid;
    logic [ENTRIES-1:0]     slot_match;
    logic [ENTRIES-1:0]     slot_kill;
    logic [ENTRIES-1:0]     slot_fill;
    logic [ENTRIES-1:0]     evict_sel;
    logic [AGE_W-1:0]       slot_age [ENTRIES];
    logic [AGE_W-1:0]       slot_age_drop [ENTRIES];
    logic [KEY_W-1:0]       slot_key [ENTRIES];
    logic [ENTRIES-1:0]     slot_dlg;

    logic                   any_match;
    logic [AGE_W-1:0]       match_age;
    logic [KEY_W-1:0]       match_key;
    logic                   match_dlg;
    logic [CNT_W-1:0]       cnt_drop;
    logic [CMP_W-1:0]       cap_wide;
    logic [CNT_W-1:0]       eff_cap;
    logic                   evict;
    logic [AGE_W-1:0]       oldest_rank;
    logic                   free_found;

    // Handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign do_insert = advance && (op_reg == OP_INSERT);

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg      <= opcode_t'(s_tuser);
            user_reg    <= s_tdata[63:0];
            profile_reg <= s_tdata[95:64];
            key_in_reg  <= s_tdata[127:96];
            dlg_in_reg  <= s_tdata[128];
        end
    end

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    // Gather the matching slot
    always_comb
    begin
        any_match = 1'b0;
        match_age = '0;
        match_key = '0;
        match_dlg = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            any_match = any_match | slot_match[i];
            match_age = match_age | (slot_age[i] & {AGE_W{slot_match[i]}});
            match_key = match_key | (slot_key[i] & {KEY_W{slot_match[i]}});
            match_dlg = match_dlg | (slot_dlg[i] & slot_match[i]);
        end
    end

    // Clamp the capacity and decide on an eviction
    always_comb
    begin
        cap_wide = CMP_W'(capacity_reg);
        if (cap_wide == '0)
            eff_cap = CNT_W'(1);
        else if (cap_wide > CMP_W'(ENTRIES))
            eff_cap = CNT_W'(ENTRIES);
        else
            eff_cap = CNT_W'(cap_wide);
        cnt_drop    = count_reg - CNT_W'(any_match);
        evict       = (op_reg == OP_INSERT) && (cnt_drop >= eff_cap) && (cnt_drop != '0);
        oldest_rank = AGE_W'(cnt_drop - CNT_W'(1));
    end

    // Pick the oldest slot, the slots to drop and the first free slot
    always_comb
    begin
        free_found = 1'b0;
        slot_fill  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            evict_sel[i] = evict && slot_valid[i] && !slot_match[i]
                           && (slot_age_drop[i] == oldest_rank);
            slot_kill[i] = slot_match[i] || evict_sel[i];
            if (!free_found && (!slot_valid[i] || slot_kill[i]))
            begin
                slot_fill[i] = 1'b1;
                free_found   = 1'b1;
            end
        end
    end

    // Broadcast command
    always_comb
    begin
        cmd.clear     = advance && (op_reg == OP_CLEAR);
        cmd.insert    = do_insert;
        cmd.any_match = any_match;
    end

    // Slots
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_slot
        khc_cell #(
            .AGE_W (AGE_W),
            .KEY_W (KEY_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .ref_age    (match_age),
            .kill       (slot_kill[g]),
            .fill       (slot_fill[g]),
            .user_id    (user_reg),
            .profile_id (profile_reg),
            .key_handle (key_in_reg[KEY_W-1:0]),
            .delegate   (dlg_in_reg),
            .valid      (slot_valid[g]),
            .match      (slot_match[g]),
            .age_q      (slot_age[g]),
            .age_drop   (slot_age_drop[g]),
            .key_q      (slot_key[g]),
            .delegate_q (slot_dlg[g])
        );
    end

    // Form the result and the next entry count
    always_comb
    begin
        hit_next     = 1'b0;
        key_out_next = '0;
        dlg_out_next = 1'b0;
        evicted_next = 1'b0;
        count_next   = count_reg;
        case (op_reg)
            OP_LOOKUP:
            begin
                hit_next = any_match;
                key_out_next[KEY_W-1:0] = match_key;
                dlg_out_next = match_dlg;
            end
            OP_INSERT:
            begin
                evicted_next = evict;
                count_next   = cnt_drop - CNT_W'(evict) + CNT_W'(1);
            end
            OP_CLEAR:
                count_next = '0;
            default:
                count_next = count_reg;
        endcase
    end

    // Advance the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (advance)
            count_reg <= count_next;
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg     <= hit_next;
            key_out_reg <= key_out_next;
            dlg_out_reg <= dlg_out_next;
            evicted_reg <= evicted_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {6'b0, evicted_reg, dlg_out_reg, key_out_reg};

endmodule

### dv/khc_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// khc_result_checker: result checker for the key handle cache
// Watches the capacity, request and result channels. Every accepted request
// runs through a cycle-free model of the cache (tag match, oldest-first
// eviction, clear), and the predicted result waits in order until the block
// returns its result, which is compared field by field.
// ---------------------------------------------------------------------------
module khc_result_checker
    import khc_pkg::*;
#(
    parameter int SLOTS = ENTRIES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [135:0]     s_tdata,   // user_id[63:0], profile_id[95:64],
                                        // key_handle_in[127:96], delegate_in[128]
    input  logic [1:0]       s_tuser,   // opcode[1:0]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [39:0]      m_tdata,   // key_handle_out[31:0], delegate_out[32],
                                        // evicted[33]
    input  logic             m_tuser,   // hit[0]
    output int               errors,
    output int               outstanding
);

    typedef struct packed {
        logic                   hit;
        logic [KEY_FIELD_W-1:0] handle;
        logic                   delegate;
        logic                   evicted;
    } cache_result_t;

    // Model of the cache contents; rank 0 is the newest valid entry
    logic                   slot_valid    [SLOTS];
    logic [USER_W-1:0]      slot_user     [SLOTS];
    logic [PROFILE_W-1:0]   slot_profile  [SLOTS];
    logic [KEY_FIELD_W-1:0] slot_handle   [SLOTS];
    logic                   slot_delegate [SLOTS];
    int                     slot_rank     [SLOTS];
    int                     entry_total;
    logic [CAP_W-1:0]       capacity_reg;

    cache_result_t          pending_results [$];
    cache_result_t          want_res;
    cache_result_t          got_res;

    // Return the slot holding this tag, or -1
    function automatic int find_tag(input logic [USER_W-1:0] user,
                                    input logic [PROFILE_W-1:0] profile);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_user[i] == user && slot_profile[i] == profile)
                return i;
        return -1;
    endfunction

    // Invalidate a slot and close the gap in the age ranks
    function automatic void remove_slot(input int s);
        int rank_gone;
        rank_gone = slot_rank[s];
        slot_valid[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_rank[i] > rank_gone)
                slot_rank[i]--;
        if (entry_total > 0)
            entry_total--;
    endfunction

    // Apply one request to the model and return the result it produces
    function automatic cache_result_t predict_result(
        input logic [1:0]             op,
        input logic [USER_W-1:0]      user,
        input logic [PROFILE_W-1:0]   profile,
        input logic [KEY_FIELD_W-1:0] handle,
        input logic                   delegate
    );
        cache_result_t r;
        int            s;
        int            limit;
        r = '0;
        case (op)
            OP_LOOKUP:
            begin
                s = find_tag(user, profile);
                if (s >= 0)
                begin
                    r.hit      = 1'b1;
                    r.handle   = slot_handle[s];
                    r.delegate = slot_delegate[s];
                end
            end
            OP_INSERT:
            begin
                // Zero acts as one, anything above the slot count as full size
                if (capacity_reg == 0)
                    limit = 1;
                else if (capacity_reg > SLOTS)
                    limit = SLOTS;
                else
                    limit = int'(capacity_reg);
                // Drop a stale copy of the tag first; that is no eviction
                s = find_tag(user, profile);
                if (s >= 0)
                    remove_slot(s);
                // Evict the single oldest entry when at or over the limit
                if (entry_total >= limit)
                begin
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && (s < 0 || slot_rank[i] > slot_rank[s]))
                            s = i;
                    if (s >= 0)
                    begin
                        remove_slot(s);
                        r.evicted = 1'b1;
                    end
                end
                // Place the new entry as newest in the lowest free slot
                s = -1;
                for (int i = 0; i < SLOTS && s < 0; i++)
                    if (!slot_valid[i])
                        s = i;
                if (s >= 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i])
                            slot_rank[i]++;
                    slot_valid[s]    = 1'b1;
                    slot_user[s]     = user;
                    slot_profile[s]  = profile;
                    slot_handle[s]   = handle;
                    slot_delegate[s] = delegate;
                    slot_rank[s]     = 0;
                    entry_total++;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_valid[i] = 1'b0;
                    slot_rank[i]  = 0;
                end
                entry_total = 0;
            end
            default:
            begin
                // Unused opcode: no state change, all-zero result
            end
        endcase
        return r;
    endfunction

    // Track capacity writes, predict on each request, compare each result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            entry_total  = 0;
            capacity_reg = CAP_RESET;
            pending_results.delete();
            errors       = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg = cfg_data;

            if (m_tvalid && m_tready)
            begin
                got_res = {m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33]};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result hit=%0b key=%08h dlg=%0b ev=%0b",
                                 $realtime, got_res.hit, got_res.handle,
                                 got_res.delegate, got_res.evicted);
                end
                else
                begin
                    want_res = pending_results.pop_front();
                    if (got_res.hit !== want_res.hit || got_res.handle !== want_res.handle ||
                        got_res.delegate !== want_res.delegate ||
                        got_res.evicted !== want_res.evicted)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch expected hit=%0b key=%08h dlg=%0b ",
                                      "ev=%0b, got hit=%0b key=%08h dlg=%0b ev=%0b"},
                                     $realtime, want_res.hit, want_res.handle,
                                     want_res.delegate, want_res.evicted, got_res.hit,
                                     got_res.handle, got_res.delegate, got_res.evicted);
                    end
                end
            end

            if (s_tvalid && s_tready)
                pending_results.push_back(predict_result(s_tuser, s_tdata[63:0],
                                                         s_tdata[95:64], s_tdata[127:96],
                                                         s_tdata[128]));

            outstanding = pending_results.size();
        end
    end

endmodule

### dv/key_handle_cache_fifo_replace_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_handle_cache_fifo_replace_tb: testbench top for the key handle cache
// Drives a directed sequence of lookups, inserts and clears, then random
// phases over a small tag pool at several capacities with varying idle and
// stall rates on both sides. The checker beside the block predicts and
// compares; this module makes stimulus, runs a watchdog and gives the verdict.
// ---------------------------------------------------------------------------
module key_handle_cache_fifo_replace_tb;
    import khc_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         TAG_POOL      = 24;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 210;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [135:0]           s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [39:0]            m_tdata;
    logic                   m_tuser;

    int                     errors;
    int                     outstanding;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    logic                   hold_request;
    int                     quiet_cycles;

    logic [USER_W-1:0]      pool_user    [TAG_POOL];
    logic [PROFILE_W-1:0]   pool_profile [TAG_POOL];

    key_handle_cache_fifo_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    khc_result_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request, idling first at the current sender rate
    task automatic send_request(input logic [1:0]             op,
                                input logic [USER_W-1:0]      user,
                                input logic [PROFILE_W-1:0]   profile,
                                input logic [KEY_FIELD_W-1:0] handle,
                                input logic                   delegate);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, delegate, handle, profile, user};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off requests until every expected result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register; call only while the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                     roll;
        int                     pick;
        logic [1:0]             op;
        logic [USER_W-1:0]      user;
        logic [PROFILE_W-1:0]   profile;
        logic [CAP_W-1:0]       cap;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;

        // Tag pool: extremes, shared user, shared profile, the rest random
        for (int i = 0; i < TAG_POOL; i++)
        begin
            pool_user[i]    = {$urandom, $urandom};
            pool_profile[i] = $urandom;
        end
        pool_user[0] = '0;  pool_profile[0] = '0;
        pool_user[1] = '1;  pool_profile[1] = '1;
        pool_user[2] = '0;  pool_profile[2] = '1;
        pool_user[3] = '1;  pool_profile[3] = '0;
        pool_user[4]    = pool_user[5];
        pool_profile[6] = pool_profile[7];

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: misses, hits, partial tag match, replace, unused op, clear
        send_request(OP_LOOKUP, '1, '1, $urandom, 1'b1);
        send_request(OP_INSERT, '0, '0, '0, 1'b0);
        send_request(OP_INSERT, '1, '1, '1, 1'b1);
        send_request(OP_LOOKUP, '0, '0, $urandom, 1'b1);
        send_request(OP_LOOKUP, '1, '1, $urandom, 1'b0);
        send_request(OP_LOOKUP, '0, '1, $urandom, 1'b0);
        send_request(OP_INSERT, '0, '0, 32'h1234_5678, 1'b1);
        send_request(OP_LOOKUP, '0, '0, $urandom, 1'b0);
        send_request(OP_UNUSED, '0, '0, $urandom, 1'b1);
        send_request(OP_LOOKUP, '1, '1, $urandom, 1'b0);
        send_request(OP_CLEAR, '1, '1, '1, 1'b1);
        send_request(OP_LOOKUP, '0, '0, $urandom, 1'b0);

        // Directed: capacity one evicts on every new tag
        wait_idle();
        write_capacity(5'd1);
        send_request(OP_INSERT, '0, '1, $urandom, 1'b1);
        send_request(OP_INSERT, '1, '0, $urandom, 1'b0);
        send_request(OP_LOOKUP, '0, '1, $urandom, 1'b0);
        send_request(OP_LOOKUP, '1, '0, $urandom, 1'b1);

        // Directed: capacity zero acts as one; reinserting a tag is no eviction
        wait_idle();
        write_capacity(5'd0);
        send_request(OP_INSERT, '0, '1, $urandom, 1'b1);
        send_request(OP_LOOKUP, '0, '1, $urandom, 1'b0);
        send_request(OP_INSERT, '0, '1, $urandom, 1'b0);

        // Random phases; no clear between them, so lowered capacities drain
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       cap = 5'd16;
                1:       cap = 5'd31;
                2:       cap = 5'd3;
                3:       cap = 5'd1;
                4:       cap = 5'd8;
                5:       cap = 5'd0;
                6:       cap = 5'd17;
                default: cap = 5'd5;
            endcase
            wait_idle();
            write_capacity(cap);

            // Rotate idling: none, sender only, receiver only, both
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 48)
                    op = OP_LOOKUP;
                else if (roll < 97)
                    op = OP_INSERT;
                else if (roll < 99)
                    op = OP_CLEAR;
                else
                    op = OP_UNUSED;

                // Mostly pool tags so hits, replaces and evictions happen
                pick = $urandom_range(0, TAG_POOL - 1);
                if ($urandom_range(0, 99) < 88)
                begin
                    user    = pool_user[pick];
                    profile = pool_profile[pick];
                end
                else
                begin
                    user    = {$urandom, $urandom};
                    profile = $urandom;
                end
                send_request(op, user, profile, $urandom, $urandom_range(0, 1));

                // Back-pressure the block until it fills, later drain fully
                if (p == 0 && n == 60)
                    hold_request = 1'b1;
                if (p == 0 && n == 140)
                    wait_idle();
            end
        end

        // Drain and settle, then report
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
